// File: hw/rtl/plist_pkg.sv
package plist_pkg;

    // List sizing
    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;

    // Field widths on the stream ports
    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int RD_W   = 32;
    localparam int LEN_W  = 7;
    localparam int ST_W   = 2;

    // Stored width: bits above the value field are always zero
    localparam int DATA_W = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Packed beat widths, rounded up to whole bytes
    localparam int S_FIELDS_W = OP_W + POS_W + VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = RD_W + LEN_W + 1 + ST_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Opcodes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_DRAIN,
        S_READ,
        S_FINISH,
        S_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the request beat
        logic check;     // latch status, set up the shift walk
        logic walk;      // one step of the shift walk
        logic drain;     // write back the last moved entry
        logic rd_pos;    // read the entry at the requested position
        logic commit;    // final write and count update
        logic load_out;  // fill the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic go_walk;   // request needs entries shifted
        logic go_read;   // request is a read at a valid position
        logic walk_last; // the walk reads its last source entry now
    } dp_stat_t;

endpackage

// File: hw/rtl/plist_dp.sv
module plist_dp
    import plist_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Entry storage, one write and one registered read per cycle
    logic [DATA_W-1:0] entries_mem [CAPACITY];

    logic [OP_W-1:0]   op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [ST_W-1:0]   status_reg;
    logic [ADDR_W-1:0] src_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic              wb_valid_reg;
    logic [DATA_W-1:0] rdata_reg;

    logic [RD_W-1:0]   out_rd_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_empty_reg;
    logic [ST_W-1:0]   out_status_reg;

    logic              is_app;
    logic              is_ins;
    logic              is_del;
    logic              is_rd;
    logic              pos_ok;
    logic              full;
    logic [ST_W-1:0]   status_now;
    logic [ADDR_W-1:0] pos_m1;
    logic [ADDR_W-1:0] cnt_m1;
    logic              ok_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Request decode and range check
    assign is_app = (op_reg == OP_APPEND);
    assign is_ins = (op_reg == OP_INSERT);
    assign is_del = (op_reg == OP_DELETE);
    assign is_rd  = (op_reg == OP_READ);
    assign pos_ok = (CMP_W'(pos_reg) != '0) && (CMP_W'(pos_reg) <= CMP_W'(cnt_reg));
    assign full   = (cnt_reg == CNT_W'(CAPACITY));
    assign pos_m1 = ADDR_W'(pos_reg - 1'b1);
    assign cnt_m1 = ADDR_W'(cnt_reg - 1'b1);
    assign ok_reg = (status_reg == ST_OK);

    always_comb begin
        status_now = ST_OK;
        case (op_reg)
            OP_APPEND: status_now = full ? ST_FULL : ST_OK;
            OP_INSERT: status_now = !pos_ok ? ST_RANGE : (full ? ST_FULL : ST_OK);
            OP_DELETE, OP_READ: status_now = pos_ok ? ST_OK : ST_RANGE;
            default: status_now = ST_OK;
        endcase
    end

    // Status to the controller
    always_comb begin
        stat.go_walk   = (status_now == ST_OK) &&
                         (is_ins || (is_del && (CMP_W'(pos_reg) != CMP_W'(cnt_reg))));
        stat.go_read   = (status_now == ST_OK) && is_rd;
        stat.walk_last = is_ins ? (src_reg == pos_m1) : (src_reg == cnt_m1);
    end

    // Memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = wb_addr_reg;
        wr_data = rdata_reg;
        if (cmd.walk || cmd.drain) begin
            wr_en = wb_valid_reg;
        end else if (cmd.commit) begin
            wr_en   = ok_reg && (is_app || is_ins);
            wr_addr = is_app ? ADDR_W'(cnt_reg) : pos_m1;
            wr_data = val_reg[DATA_W-1:0];
        end
        rd_en   = cmd.walk || cmd.rd_pos;
        rd_addr = cmd.walk ? src_reg : pos_m1;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entries_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= entries_mem[rd_addr];
        end
    end

    // Entry count
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.commit && ok_reg) begin
            if (is_app || is_ins) begin
                cnt_next = cnt_reg + 1'b1;
            end else if (is_del) begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            wb_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.check || cmd.drain) begin
                wb_valid_reg <= 1'b0;
            end else if (cmd.walk) begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // Request capture and shift walk pointers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tdata[OP_W-1:0];
            pos_reg <= s_tdata[OP_W +: POS_W];
            val_reg <= s_tdata[OP_W+POS_W +: VAL_W];
        end
        if (cmd.check) begin
            status_reg <= status_now;
            src_reg    <= is_ins ? cnt_m1 : ADDR_W'(pos_reg);
        end
        if (cmd.walk) begin
            wb_addr_reg <= is_ins ? src_reg + 1'b1 : src_reg - 1'b1;
            src_reg     <= is_ins ? src_reg - 1'b1 : src_reg + 1'b1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_rd_reg     <= (is_rd && ok_reg) ? RD_W'(rdata_reg) : '0;
            out_len_reg    <= LEN_W'(cnt_reg);
            out_empty_reg  <= (cnt_reg == '0);
            out_status_reg <= status_reg;
        end
    end

    assign m_tdata = {{M_PAD_W{1'b0}}, out_status_reg, out_empty_reg, out_len_reg, out_rd_reg};

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_cnt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.commit |=> $stable(cnt_reg))
        else $error("entry count moved outside commit");

    a_cnt_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && ok_reg && (is_app || is_ins) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("append or insert did not grow the list");

endmodule

// File: hw/rtl/plist_ctrl.sv
module plist_ctrl
    import plist_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (stat.go_walk) begin
                    state_next = S_WALK;
                end else if (stat.go_read) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (stat.walk_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                cmd.drain  = 1'b1;
                state_next = S_FINISH;
            end
            S_READ: begin
                cmd.rd_pos = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result valid: set on load, cleared when the beat is taken
    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_CHECK)
        else $error("accepted beat did not start a check");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && out_free |=> m_tvalid_reg && state_reg == S_IDLE)
        else $error("result not presented after finish");

    a_walk_stay: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK && !stat.walk_last |=> state_reg == S_WALK)
        else $error("shift walk left early");

endmodule

// File: hw/rtl/positional_list_engine_top.sv
// Positional list engine: an ordered list of up to CAPACITY values, addressed
// by 1-based position.
// Input channel s_*: one beat per request (append, insert before position,
// delete at position, read at position, query). Output channel m_*: exactly
// one result beat per request with the read value, length, empty flag and
// status, in request order.
// Timing: a request is taken only while the engine is idle. Every request passes
// through the check, finish and output states; a read adds a read state. The
// next request can be accepted as soon as the result beat is presented. Insert
// shifts every entry from the position to the end up one slot, delete shifts
// the entries after the position down one slot; the walk moves one entry per
// cycle through the entry memory (one read and one write port), followed by a
// drain state.
// A finished result sits in an output register; the next request is
// accepted while it waits, and the engine holds its next result until
// m_tready frees the register.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result. Entry storage is not cleared; only written slots are ever read.
module positional_list_engine_top
    import plist_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // opcode, position, value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // read_value, length, is_empty, status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    plist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plist_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
